FILE: hw/rtl/hi2xy_pkg.sv
// ----------------------------------------------------------------------------
// hi2xy_pkg
// Shared constants and types for the Hilbert index to x,y pipeline.
// ----------------------------------------------------------------------------
package hi2xy_pkg;

	localparam int IDX_W            = 32;  // curve index width
	localparam int COORD_W          = 16;  // output coordinate width
	localparam int ORDER_W          = 5;   // curve_order register width
	localparam int LEVELS_PER_STAGE = 4;   // curve levels resolved per pipe stage
	localparam int IDX_PAIRS        = IDX_W / 2;

	localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(4);

	// control bits that travel with each transaction
	typedef struct packed {
		logic valid;
		logic oor;     // index beyond 4^order
	} hi2xy_ctrl_t;

endpackage

FILE: hw/rtl/hi2xy_front.sv
// ----------------------------------------------------------------------------
// hi2xy_front
// Entry stage: order clamp, range check and base cell from the low bit pair.
// ----------------------------------------------------------------------------
module hi2xy_front import hi2xy_pkg::*; #(
	parameter int MAX_ORDER = 16,
	parameter int OW        = $clog2(MAX_ORDER + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [IDX_W-1:0]     in_idx,
	input  logic [ORDER_W-1:0]   curve_order,
	output hi2xy_ctrl_t          ctrl_s1,
	output logic [IDX_W-1:0]     idx_s1,
	output logic [OW-1:0]        ord_s1,
	output logic [MAX_ORDER-1:0] x_s1,
	output logic [MAX_ORDER-1:0] y_s1
);

	localparam int CMP_W = (ORDER_W > OW) ? ORDER_W + 1 : OW + 1;

	logic [CMP_W-1:0]     ord_ext;
	logic [OW-1:0]        ord_eff;
	logic                 oor;
	logic [MAX_ORDER-1:0] x_base;
	logic [MAX_ORDER-1:0] y_base;

	// order 0 behaves as 1, anything above MAX_ORDER saturates
	always_comb begin
		ord_ext = CMP_W'(curve_order);
		if (ord_ext == '0) begin
			ord_eff = OW'(1);
		end else if (ord_ext > CMP_W'(MAX_ORDER)) begin
			ord_eff = OW'(MAX_ORDER);
		end else begin
			ord_eff = ord_ext[OW-1:0];
		end
	end

	// out of range when any bit pair at or above the order is set
	always_comb begin
		oor = 1'b0;
		for (int p = 0; p < IDX_PAIRS; p++) begin
			if ((p >= int'(ord_eff)) && (in_idx[2*p +: 2] != 2'b00)) begin
				oor = 1'b1;
			end
		end
	end

	// base cell: 0 -> (0,0), 1 -> (0,1), 2 -> (1,1), 3 -> (1,0)
	always_comb begin
		x_base = '0;
		y_base = '0;
		if (!oor) begin
			x_base[0] = in_idx[1];
			y_base[0] = in_idx[1] ^ in_idx[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid <= in_valid;
			ctrl_s1.oor   <= oor;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= in_idx;
		ord_s1 <= ord_eff;
		x_s1   <= x_base;
		y_s1   <= y_base;
	end

endmodule

FILE: hw/rtl/hi2xy_level.sv
// ----------------------------------------------------------------------------
// hi2xy_level
// One pipe stage resolving a group of consecutive curve levels.
// ----------------------------------------------------------------------------
module hi2xy_level import hi2xy_pkg::*; #(
	parameter int MAX_ORDER   = 16,
	parameter int OW          = $clog2(MAX_ORDER + 1),
	parameter int FIRST_LEVEL = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hi2xy_ctrl_t          ctrl_in,
	input  logic [IDX_W-1:0]     idx_in,
	input  logic [OW-1:0]        ord_in,
	input  logic [MAX_ORDER-1:0] x_in,
	input  logic [MAX_ORDER-1:0] y_in,
	output hi2xy_ctrl_t          ctrl_sn,
	output logic [IDX_W-1:0]     idx_sn,
	output logic [OW-1:0]        ord_sn,
	output logic [MAX_ORDER-1:0] x_sn,
	output logic [MAX_ORDER-1:0] y_sn
);

	localparam int W = MAX_ORDER;

	logic [W-1:0] x_nxt;
	logic [W-1:0] y_nxt;

	// x,y stay below 2^lvl, so side-1-v is ~v under a low mask and +side sets bit lvl
	always_comb begin
		logic [W-1:0] x_t;
		logic [W-1:0] y_t;
		logic [W-1:0] side;
		logic [W-1:0] low_mask;
		logic [1:0]   q;
		int           lvl;
		x_t = x_in;
		y_t = y_in;
		for (int k = 0; k < LEVELS_PER_STAGE; k++) begin
			lvl      = FIRST_LEVEL + k;
			side     = W'(1) << lvl;
			low_mask = side - W'(1);
			q        = 2'b00;
			if (2 * lvl < IDX_W) begin
				q = idx_in[2*lvl +: 2];
			end
			if ((lvl < MAX_ORDER) && (lvl < int'(ord_in)) && !ctrl_in.oor) begin
				case (q)
					2'b00: begin
						{x_t, y_t} = {y_t, x_t};
					end
					2'b01: begin
						y_t = y_t | side;
					end
					2'b10: begin
						x_t = x_t | side;
						y_t = y_t | side;
					end
					2'b11: begin
						{x_t, y_t} = {(low_mask & ~y_t) | side, low_mask & ~x_t};
					end
					default: begin
						x_t = x_t;
					end
				endcase
			end
		end
		x_nxt = x_t;
		y_nxt = y_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_sn <= '0;
		end else begin
			ctrl_sn <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		idx_sn <= idx_in;
		ord_sn <= ord_in;
		x_sn   <= x_nxt;
		y_sn   <= y_nxt;
	end

endmodule

FILE: hw/rtl/hilbert_index_to_xy_top.sv
// Throughput: one transaction per cycle; busy is always low, one pipe stage per
//   group of four curve levels sets the depth, the receiver cannot stall.
// Reset: arst_n clears all valid bits and sets curve_order to 4; coordinate
//   registers are not reset.
// ----------------------------------------------------------------------------
// hilbert_index_to_xy_top
// Maps a Hilbert curve position to its x,y grid coordinate, fully pipelined.
// ----------------------------------------------------------------------------
module hilbert_index_to_xy_top import hi2xy_pkg::*; #(
	parameter int MAX_ORDER = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [ORDER_W-1:0] cfg_wr_data,
	// command
	input  logic               start,
	output logic               busy,
	input  logic [IDX_W-1:0]   curve_index,
	// result
	output logic               done,
	output logic [COORD_W-1:0] coord_x,
	output logic [COORD_W-1:0] coord_y,
	output logic               out_of_range
);

	localparam int OW = $clog2(MAX_ORDER + 1);
	// levels 1 .. MAX_ORDER-1 in groups; keep at least one stage
	localparam int NUM_STAGES = (MAX_ORDER > 1) ?
		(MAX_ORDER - 1 + LEVELS_PER_STAGE - 1) / LEVELS_PER_STAGE : 1;

	logic [ORDER_W-1:0] curve_order_q;

	hi2xy_ctrl_t          ctrl_p [0:NUM_STAGES];
	logic [IDX_W-1:0]     idx_p  [0:NUM_STAGES];
	logic [OW-1:0]        ord_p  [0:NUM_STAGES];
	logic [MAX_ORDER-1:0] x_p    [0:NUM_STAGES];
	logic [MAX_ORDER-1:0] y_p    [0:NUM_STAGES];

	// order register; the user must write it only while the pipe is empty, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_order_q <= ORDER_RESET;
		end else if (cfg_wr_en) begin
			curve_order_q <= cfg_wr_data;
		end
	end

	// every stage advances each cycle, so a new transaction is always taken
	assign busy = 1'b0;

	// entry stage: clamp order, range check, base cell
	hi2xy_front #(
		.MAX_ORDER (MAX_ORDER),
		.OW        (OW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start),
		.in_idx      (curve_index),
		.curve_order (curve_order_q),
		.ctrl_s1     (ctrl_p[0]),
		.idx_s1      (idx_p[0]),
		.ord_s1      (ord_p[0]),
		.x_s1        (x_p[0]),
		.y_s1        (y_p[0])
	);

	// level stages: each applies the swap / reflect / offset for up to four levels
	for (genvar s = 0; s < NUM_STAGES; s++) begin : g_level
		hi2xy_level #(
			.MAX_ORDER   (MAX_ORDER),
			.OW          (OW),
			.FIRST_LEVEL (1 + s * LEVELS_PER_STAGE)
		) u_level (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl_in (ctrl_p[s]),
			.idx_in  (idx_p[s]),
			.ord_in  (ord_p[s]),
			.x_in    (x_p[s]),
			.y_in    (y_p[s]),
			.ctrl_sn (ctrl_p[s+1]),
			.idx_sn  (idx_p[s+1]),
			.ord_sn  (ord_p[s+1]),
			.x_sn    (x_p[s+1]),
			.y_sn    (y_p[s+1])
		);
	end

	// result straight from the last stage flops; out-of-range items carry zeros
	assign done         = ctrl_p[NUM_STAGES].valid;
	assign out_of_range = ctrl_p[NUM_STAGES].oor;
	assign coord_x      = COORD_W'(x_p[NUM_STAGES]);
	assign coord_y      = COORD_W'(y_p[NUM_STAGES]);

endmodule
